[src/rbib_pkg.sv]
// Package for the rollback input history buffer.
// Holds sizes, command codes and the control bundle sent to the slot cells.
// No dependencies.
`default_nettype none
package rbib_pkg;

	localparam int PLAYERS    = 2;
	localparam int WINDOW     = 64;
	localparam int INPUT_BITS = 8;

	localparam int PLR_W  = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);

	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	typedef logic [INPUT_BITS-1:0] inp_t;
	typedef inp_t [PLAYERS-1:0] row_t;

	typedef struct packed {
		logic              shift;
		logic              wr;
		logic              fill;
		logic              rd_load;
		logic              rd_shift;
		logic [PLR_W-1:0]  player;
		inp_t              value;
		logic [SLOT_W-1:0] slot;
	} ctrl_t;

endpackage
`default_nettype wire

[src/rbib_cell.sv]
// One slot of the history window: the input of every player for one frame age.
// Shifts from its newer neighbor, takes writes and fills, and passes read data down.
// Depends on rbib_pkg.
`default_nettype none
module rbib_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [rbib_pkg::SLOT_W-1:0] idx,
	input  rbib_pkg::ctrl_t             ctrl,
	input  rbib_pkg::row_t              prev_row,
	input  rbib_pkg::inp_t              next_rd,
	output rbib_pkg::row_t              row,
	output rbib_pkg::inp_t              rd
);
	import rbib_pkg::*;

	row_t row_q;
	inp_t rd_q;
	logic hit;
	logic below;

	assign hit   = (idx == ctrl.slot);
	assign below = (idx < ctrl.slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctrl.shift) begin
			row_q <= prev_row;
		end else if (ctrl.wr && (hit || (ctrl.fill && below))) begin
			row_q[ctrl.player] <= ctrl.value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_load) begin
			rd_q <= hit ? row_q[ctrl.player] : '0;
		end else if (ctrl.rd_shift) begin
			rd_q <= next_rd;
		end
	end

	assign row = row_q;
	assign rd  = rd_q;

endmodule
`default_nettype wire

[src/rollback_input_history_buffer.sv]
// Top level of the rollback input history buffer: control sequencer and the row of slot cells.
// Depends on rbib_pkg and rbib_cell.
//
// One item at a time. After an item is accepted the sequencer steps through prep, then the
// window shift for a start or set whose frame is newer, then act, then write for a set or
// read load and read shift for a read (skipped for a flagged item), then done. The window
// advances one cell per cycle, by as many slots as the frame moved, at most WINDOW. Read
// data walks down the cell row one cell per cycle, once per slot of age. Done waits while
// an earlier result is still held at the output. One result item per input item; the next
// input item is taken while a result still waits at the output.
`default_nettype none
module rollback_input_history_buffer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,  // player[0], input_value[8:1], frame[40:9], zeros
	input  wire  [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,  // read_value[7:0], now_frame[39:8]
	output logic        m_tuser   // status[0]
);
	import rbib_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_PREP    = 3'd1;
	localparam logic [2:0] ST_SHIFT   = 3'd2;
	localparam logic [2:0] ST_ACT     = 3'd3;
	localparam logic [2:0] ST_WRITE   = 3'd4;
	localparam logic [2:0] ST_RDLOAD  = 3'd5;
	localparam logic [2:0] ST_RDSHIFT = 3'd6;
	localparam logic [2:0] ST_DONE    = 3'd7;

	logic [2:0]              state_q;
	logic [1:0]              cmd_q;
	logic                    player_q;
	inp_t                    val_q;
	logic [31:0]             frame_q;
	logic [31:0]             cur_q;
	logic [PLAYERS-1:0][31:0] last_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SLOT_W-1:0]       slot_q;
	logic                    fill_q;
	inp_t                    res_val_q;
	logic                    res_stat_q;
	logic [7:0]              out_val_q;
	logic                    out_stat_q;
	logic [31:0]             out_frame_q;
	logic                    out_valid_q;

	logic [31:0]      delta;
	logic [31:0]      age;
	logic             bad;
	logic [PLR_W-1:0] pidx;
	ctrl_t            ctrl;
	row_t             rows [WINDOW];
	inp_t             rds  [WINDOW];

	assign delta = frame_q - cur_q;
	assign age   = cur_q - frame_q;
	assign pidx  = PLR_W'(player_q);
	assign bad   = ({31'b0, player_q} >= 32'(PLAYERS)) || (age >= 32'(WINDOW));

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		ctrl          = '0;
		ctrl.shift    = (state_q == ST_SHIFT);
		ctrl.wr       = (state_q == ST_WRITE);
		ctrl.fill     = fill_q;
		ctrl.rd_load  = (state_q == ST_RDLOAD);
		ctrl.rd_shift = (state_q == ST_RDSHIFT);
		ctrl.player   = pidx;
		ctrl.value    = val_q;
		ctrl.slot     = slot_q;
	end

	genvar k;
	generate
		for (k = 0; k < WINDOW; k++) begin : g_cell
			rbib_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.idx      (SLOT_W'(k)),
				.ctrl     (ctrl),
				.prev_row ((k == 0) ? rows[0] : rows[(k == 0) ? 0 : k - 1]),
				.next_rd  ((k == WINDOW - 1) ? inp_t'(0) : rds[(k == WINDOW - 1) ? k : k + 1]),
				.row      (rows[k]),
				.rd       (rds[k])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q    <= s_tuser;
			player_q <= s_tdata[0];
			val_q    <= s_tdata[8:1];
			frame_q  <= s_tdata[40:9];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			last_q      <= '0;
			cnt_q       <= '0;
			slot_q      <= '0;
			fill_q      <= 1'b0;
			res_val_q   <= '0;
			res_stat_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_val_q   <= '0;
			out_stat_q  <= 1'b0;
			out_frame_q <= '0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					res_val_q  <= '0;
					res_stat_q <= 1'b0;
					fill_q     <= 1'b0;
					if ((cmd_q == CMD_SET || cmd_q == CMD_START) && frame_q > cur_q) begin
						cur_q   <= frame_q;
						cnt_q   <= (delta >= 32'(WINDOW)) ? CNT_W'(WINDOW) : CNT_W'(delta);
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_ACT;
					end
				end
				ST_SHIFT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					slot_q <= age[SLOT_W-1:0];
					cnt_q  <= CNT_W'(age[SLOT_W-1:0]);
					fill_q <= last_q[pidx] < frame_q;
					case (cmd_q)
						CMD_SET: begin
							res_stat_q <= bad;
							state_q    <= bad ? ST_DONE : ST_WRITE;
						end
						CMD_READ: begin
							res_stat_q <= bad;
							state_q    <= bad ? ST_DONE : ST_RDLOAD;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_WRITE: begin
					if (fill_q) begin
						last_q[pidx] <= frame_q;
					end
					state_q <= ST_DONE;
				end
				ST_RDLOAD: begin
					state_q <= ST_RDSHIFT;
				end
				ST_RDSHIFT: begin
					if (cnt_q == '0) begin
						res_val_q <= rds[0];
						state_q   <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_val_q   <= 8'(res_val_q);
						out_stat_q  <= res_stat_q;
						out_frame_q <= cur_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_frame_q, out_val_q};
	assign m_tuser  = out_stat_q;

`ifndef ASSERT_OFF
	a_frame_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cur_q >= $past(cur_q))
		else $error("current frame moved backward");

	a_flag_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0)
		else $error("flagged result carries read data");

	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> cnt_q != '0 && cnt_q <= CNT_W'(WINDOW))
		else $error("window shift count out of range");

	a_hold_output: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_valid_q && !m_tready |=> state_q == ST_DONE)
		else $error("result dropped while output stalled");
`endif

endmodule
`default_nettype wire
